### src/gcr_pkg.sv
// Shared types, constants and the constant log2 table for the gamma correction block.
`default_nettype none

package gcr_pkg;

   // Fixed widths of the pixel fields and registers.
   localparam int CH_W    = 8;
   localparam int GAMMA_W = 16;
   localparam int LOG_W   = 61;               // 3 integer bits, 58 fraction bits
   localparam int PROD_W  = LOG_W + GAMMA_W;  // exact gamma times log difference
   localparam int NUM_LANES = 3;

   localparam logic [GAMMA_W-1:0] GAMMA_ONE = 16'd4096;   // 1.0 in Q4.12
   localparam logic [CH_W-1:0]    CH_FULL   = 8'hFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GAMMA      = 2'd0;
   localparam logic [1:0] CSR_PREV_GAMMA = 2'd1;
   localparam logic [1:0] CSR_DEPTH      = 2'd2;

   typedef logic [LOG_W-1:0] log_type;
   typedef log_type log_table_type [256];

   // What one lane hands to the merge stage.
   typedef struct packed {
      logic [CH_W-1:0] src;
      logic [CH_W-1:0] old;
      logic [CH_W-1:0] corr;
   } lane_res_type;

   // Truncated log2 in Q58 by repeated squaring of a Q62 mantissa.
   function automatic log_type log2_q58(input int unsigned n);
      int unsigned   k;
      logic [63:0]   m;
      logic [57:0]   frac;
      logic [127:0]  p;
      logic [63:0]   sq;
      k = 0;
      for (int j = 0; j < 7; j++) begin
         if ((n >> (k + 1)) != 0) k = k + 1;
      end
      m    = 64'(n) << (62 - k);
      frac = '0;
      for (int i = 0; i < 58; i++) begin
         p    = {64'b0, m} * {64'b0, m};
         sq   = p[125:62];
         frac = {frac[56:0], sq[63]};
         m    = sq[63] ? {1'b0, sq[63:1]} : sq;
      end
      return {3'(k), frac};
   endfunction

   function automatic log_table_type build_log_table();
      log_table_type t;
      for (int n = 0; n < 256; n++) t[n] = log2_q58(n);
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();
   localparam log_type       LOG_FULL  = log2_q58(255);

endpackage

`default_nettype wire

### src/gamma_correct_rgb_pixel_top.sv
// Top level of the gamma correction block: registers, lanes and the merge stage.
//
// Usage: one pixel (three source channels and three old output channels) is
// transferred on the req_ channel when req_valid is high and req_stall low.
// The corrected pixel is transferred on the rsp_ channel the same way.
// Each channel runs in its own lane: a pipelined bitwise search over the
// 8 result bits, two stages per bit (one 16x61 multiply, then a 77-bit
// compare against the source log distance) using a constant log2 table.
// Throughput is one pixel per cycle while req_stall is low; the lanes take a
// new pixel each cycle unless the pipeline holds. When the receiver stalls
// with a result waiting, the whole pipeline holds and req_stall is raised in
// the same cycle. Reset clears all stage valid bits and loads gamma 1.0,
// previous gamma 1.0 and 24-bit depth. The user must write the registers
// through csr_ only while idle; the block itself does not enforce this.
`default_nettype none

module gamma_correct_rgb_pixel_top
   import gcr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [GAMMA_W-1:0]  csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CH_W-1:0]     req_src_ch0,
   input  wire logic [CH_W-1:0]     req_src_ch1,
   input  wire logic [CH_W-1:0]     req_src_ch2,
   input  wire logic [CH_W-1:0]     req_old_ch0,
   input  wire logic [CH_W-1:0]     req_old_ch1,
   input  wire logic [CH_W-1:0]     req_old_ch2,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CH_W-1:0]          rsp_out_ch0,
   output logic [CH_W-1:0]          rsp_out_ch1,
   output logic [CH_W-1:0]          rsp_out_ch2
);

   localparam int DEPTH = 2 * CH_W + 1;

   logic [GAMMA_W-1:0] gamma_ff;
   logic [GAMMA_W-1:0] prev_gamma_ff;
   logic               depth_ff;
   logic               valid_ff [0:DEPTH-1];
   logic               adv;
   logic [CH_W-1:0]    src   [NUM_LANES];
   logic [CH_W-1:0]    old   [NUM_LANES];
   lane_res_type       lanes [NUM_LANES];
   logic [CH_W-1:0]    out_ch [NUM_LANES];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff      <= GAMMA_ONE;
         prev_gamma_ff <= GAMMA_ONE;
         depth_ff      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAMMA:      gamma_ff      <= csr_wdata;
            CSR_PREV_GAMMA: prev_gamma_ff <= csr_wdata;
            CSR_DEPTH:      depth_ff      <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   // The pipeline moves unless a result is waiting on a stalled receiver.
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < DEPTH; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   assign src[0] = req_src_ch0;
   assign src[1] = req_src_ch1;
   assign src[2] = req_src_ch2;
   assign old[0] = req_old_ch0;
   assign old[1] = req_old_ch1;
   assign old[2] = req_old_ch2;

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      gcr_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .gamma  (gamma_ff),
         .src_in (src[c]),
         .old_in (old[c]),
         .res    (lanes[c])
      );
   end

   gcr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .valid_in   (valid_ff[DEPTH-1]),
      .gamma      (gamma_ff),
      .prev_gamma (prev_gamma_ff),
      .depth_24   (depth_ff),
      .lanes      (lanes),
      .rsp_valid  (rsp_valid),
      .out_ch     (out_ch)
   );

   assign rsp_out_ch0 = out_ch[0];
   assign rsp_out_ch1 = out_ch[1];
   assign rsp_out_ch2 = out_ch[2];

endmodule

`default_nettype wire

### src/gcr_lane.sv
// One channel lane: a pipelined bitwise search for the exact corrected value.
`default_nettype none

module gcr_lane
   import gcr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                adv,
   input  wire logic [GAMMA_W-1:0]  gamma,
   input  wire logic [CH_W-1:0]     src_in,
   input  wire logic [CH_W-1:0]     old_in,
   output lane_res_type             res
);

   localparam int LAST = 2 * CH_W;

   logic [CH_W-1:0]   src_ff  [0:LAST];
   logic [CH_W-1:0]   old_ff  [0:LAST];
   logic [CH_W-1:0]   r_ff    [0:LAST];
   logic [LOG_W-1:0]  dx_ff   [0:LAST-1];
   logic [PROD_W-1:0] prod_ff [0:CH_W-1];
   logic              eq_ff   [0:CH_W-1];
   logic [CH_W-1:0]   cand_ff [0:CH_W-1];

   // Input stage: take the source log distance from full scale.
   always_ff @(posedge clock) begin
      if (adv) begin
         src_ff[0] <= src_in;
         old_ff[0] <= old_in;
         r_ff[0]   <= '0;
         dx_ff[0]  <= LOG_FULL - LOG_TABLE[src_in];
      end
   end

   // Each result bit takes two stages: multiply, then compare and decide.
   for (genvar i = 0; i < CH_W; i++) begin : g_bit
      localparam int A = 2 * i + 1;
      localparam int B = 2 * i + 2;
      localparam logic [CH_W-1:0] BIT_MASK = CH_W'(1 << (CH_W - 1 - i));

      logic [CH_W-1:0]  cand;
      logic [LOG_W-1:0] dy;
      logic             fits;

      assign cand = r_ff[A-1] | BIT_MASK;
      assign dy   = LOG_FULL - LOG_TABLE[cand];

      // Exact equality only occurs for unit gamma or a full-scale source.
      always_ff @(posedge clock) begin
         if (adv) begin
            cand_ff[i] <= cand;
            eq_ff[i]   <= (cand == src_ff[A-1]) &&
                          ((gamma == GAMMA_ONE) || (src_ff[A-1] == CH_FULL));
            prod_ff[i] <= PROD_W'(gamma) * PROD_W'(dy);
            src_ff[A]  <= src_ff[A-1];
            old_ff[A]  <= old_ff[A-1];
            r_ff[A]    <= r_ff[A-1];
            dx_ff[A]   <= dx_ff[A-1];
         end
      end

      assign fits = eq_ff[i] ||
                    (prod_ff[i] >= {{(PROD_W-LOG_W-12){1'b0}}, dx_ff[A], 12'b0});

      always_ff @(posedge clock) begin
         if (adv) begin
            src_ff[B] <= src_ff[A];
            old_ff[B] <= old_ff[A];
            r_ff[B]   <= fits ? cand_ff[i] : r_ff[A];
         end
      end

      if (B < LAST) begin : g_dx
         always_ff @(posedge clock) begin
            if (adv) dx_ff[B] <= dx_ff[A];
         end
      end
   end

   assign res.src  = src_ff[LAST];
   assign res.old  = old_ff[LAST];
   assign res.corr = r_ff[LAST];

endmodule

`default_nettype wire

### src/gcr_merge.sv
// Merge stage: special cases, clamping, depth select and the output register.
`default_nettype none

module gcr_merge
   import gcr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                valid_in,
   input  wire logic [GAMMA_W-1:0]  gamma,
   input  wire logic [GAMMA_W-1:0]  prev_gamma,
   input  wire logic                depth_24,
   input  wire lane_res_type        lanes [NUM_LANES],
   output logic                     rsp_valid,
   output logic [CH_W-1:0]          out_ch [NUM_LANES]
);

   logic                rsp_valid_ff;
   logic [CH_W-1:0]     out_ff [NUM_LANES];
   logic [CH_W-1:0]     out_in [NUM_LANES];
   logic                clamp_black;
   logic                clamp_white;

   assign clamp_black = (gamma < prev_gamma) && (gamma < GAMMA_ONE);
   assign clamp_white = (gamma > prev_gamma) && (gamma > GAMMA_ONE);

   // Per channel final value.
   always_comb begin
      for (int c = 0; c < NUM_LANES; c++) begin
         priority if (lanes[c].src == '0) begin
            out_in[c] = '0;
         end else if (gamma == '0) begin
            out_in[c] = (lanes[c].src == CH_FULL) ? CH_FULL : '0;
         end else begin
            out_in[c] = lanes[c].corr;
         end
         if (out_in[c] > lanes[c].old && clamp_black) out_in[c] = '0;
         if (out_in[c] < lanes[c].old && clamp_white) out_in[c] = CH_FULL;
         if (!depth_24) out_in[c] = lanes[c].old;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_ch    = out_ff;

endmodule

`default_nettype wire

### sim/gamma_pixel_checker.sv
// Checker for the gamma correction block: mirrors the registers, predicts and compares pixels.
`default_nettype none

module gamma_pixel_checker
   import gcr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [GAMMA_W-1:0]  csr_wdata,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [CH_W-1:0]     req_src_ch0,
   input  wire logic [CH_W-1:0]     req_src_ch1,
   input  wire logic [CH_W-1:0]     req_src_ch2,
   input  wire logic [CH_W-1:0]     req_old_ch0,
   input  wire logic [CH_W-1:0]     req_old_ch1,
   input  wire logic [CH_W-1:0]     req_old_ch2,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [CH_W-1:0]     rsp_out_ch0,
   input  wire logic [CH_W-1:0]     rsp_out_ch1,
   input  wire logic [CH_W-1:0]     rsp_out_ch2,
   output int                       fail_count,
   output int                       pixels_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   // Local copy of the configuration registers.
   logic [GAMMA_W-1:0] cur_gamma;
   logic [GAMMA_W-1:0] last_gamma;
   logic               full_depth;

   // Corrected pixels waiting for their transfer on the result side.
   logic [3*CH_W-1:0] corrected_q [$];

   assign pixels_pending = corrected_q.size();

   // Truncated log2 of n (1..255) with 58 fraction bits.
   function automatic logic [63:0] log2_fixed(input int unsigned n);
      int unsigned   msb;
      logic [63:0]   mant;
      logic [63:0]   sqr;
      logic [127:0]  prod;
      logic [57:0]   bits;
      msb = 0;
      while (msb < 7 && (n >> (msb + 1)) != 0) msb++;
      mant = 64'(n) << (62 - msb);
      bits = '0;
      for (int i = 0; i < 58; i++) begin
         prod = {64'b0, mant} * {64'b0, mant};
         sqr  = prod[125:62];
         bits = {bits[56:0], sqr[63]};
         mant = sqr[63] ? (sqr >> 1) : sqr;
      end
      return (64'(msb) << 58) | 64'(bits);
   endfunction

   // Exact test of y^g * 255^4096 == x^4096 * 255^g by prime exponents.
   function automatic bit powers_equal(input int unsigned y, input int unsigned x,
                                       input longint unsigned g);
      int unsigned       ry, rx, rw;
      longint unsigned   ey, ex, ew;
      ry = y;
      rx = x;
      rw = 255;
      for (int unsigned p = 2; p <= 255; p++) begin
         ey = 0;
         ex = 0;
         ew = 0;
         while (ry % p == 0) begin
            ry = ry / p;
            ey++;
         end
         while (rx % p == 0) begin
            rx = rx / p;
            ex++;
         end
         while (rw % p == 0) begin
            rw = rw / p;
            ew++;
         end
         if (g * ey + 4096 * ew != 4096 * ex + g * ew) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Largest y with y <= 255 * (x/255)^(4096/g).
   function automatic logic [CH_W-1:0] gamma_channel(input int unsigned x,
                                                     input logic [GAMMA_W-1:0] g);
      int unsigned   lo, hi, mid;
      logic [63:0]   lfull, dx, dy;
      logic [127:0]  lhs, rhs;
      bit            ok;
      if (x == 0) return '0;
      if (g == 0) return (x == 255) ? 8'd255 : 8'd0;
      lfull = log2_fixed(255);
      dx = lfull - log2_fixed(x);
      rhs = {64'b0, dx} << 12;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         ok = powers_equal(mid, x, longint'(g));
         if (!ok) begin
            dy = lfull - log2_fixed(mid);
            lhs = {112'b0, g} * {64'b0, dy};
            ok = (lhs >= rhs);
         end
         if (ok) lo = mid;
         else hi = mid - 1;
      end
      return CH_W'(lo);
   endfunction

   // One channel after correction and the clamp against the old output, or the old output when not at full depth.
   function automatic logic [CH_W-1:0] clamp_channel(input logic [CH_W-1:0] src,
                                                     input logic [CH_W-1:0] old);
      logic [CH_W-1:0] v;
      if (!full_depth) return old;
      v = gamma_channel(src, cur_gamma);
      if (v > old && cur_gamma < last_gamma && cur_gamma < GAMMA_ONE) v = '0;
      if (v < old && cur_gamma > last_gamma && cur_gamma > GAMMA_ONE) v = CH_FULL;
      return v;
   endfunction

   // Track writes, queue predictions on input transfers, compare on result transfers.
   always @(posedge clock) begin
      logic [3*CH_W-1:0] want;
      logic [3*CH_W-1:0] got;
      if (reset) begin
         cur_gamma  <= GAMMA_ONE;
         last_gamma <= GAMMA_ONE;
         full_depth <= 1'b1;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAMMA: begin
                  cur_gamma <= csr_wdata;
               end
               CSR_PREV_GAMMA: begin
                  last_gamma <= csr_wdata;
               end
               CSR_DEPTH: begin
                  full_depth <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            corrected_q.push_back({clamp_channel(req_src_ch2, req_old_ch2),
                                   clamp_channel(req_src_ch1, req_old_ch1),
                                   clamp_channel(req_src_ch0, req_old_ch0)});
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_ch2, rsp_out_ch1, rsp_out_ch0};
            if (corrected_q.size() == 0) begin
               if (fail_count < 10) $display("Unexpected result transfer: %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = corrected_q.pop_front();
               if (want !== got) begin
                  if (fail_count < 10) begin
                     $display({"Pixel mismatch: expected ch0=%0d ch1=%0d ch2=%0d, ",
                               "got ch0=%0d ch1=%0d ch2=%0d"},
                              want[7:0], want[15:8], want[23:16],
                              got[7:0], got[15:8], got[23:16]);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

### sim/testbench.sv
// Stimulus, idling control and verdict for the gamma correction block.
`default_nettype none

module testbench
   import gcr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int ITEMS_PER_SET  = 60;
   localparam int NUM_SETS       = 8;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [GAMMA_W-1:0]  csr_wdata;
   logic                req_valid;
   logic                req_stall;
   logic [CH_W-1:0]     req_src_ch0, req_src_ch1, req_src_ch2;
   logic [CH_W-1:0]     req_old_ch0, req_old_ch1, req_old_ch2;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CH_W-1:0]     rsp_out_ch0, rsp_out_ch1, rsp_out_ch2;
   int                  fail_count;
   int                  pixels_pending;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  quiet_cycles;

   // Gamma settings walked by the random phases: current, previous, depth.
   logic [GAMMA_W-1:0]  set_gamma [NUM_SETS] = '{16'd4096, 16'd1, 16'd65535, 16'd2048,
                                                 16'd9011, 16'd4096, 16'd12345, 16'd3000};
   logic [GAMMA_W-1:0]  set_prev  [NUM_SETS] = '{16'd4096, 16'd65535, 16'd1, 16'd4096,
                                                 16'd4096, 16'd4096, 16'd20000, 16'd1000};
   logic                set_depth [NUM_SETS] = '{1'b1, 1'b1, 1'b1, 1'b1,
                                                 1'b1, 1'b0, 1'b1, 1'b1};

   gamma_correct_rgb_pixel_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_src_ch0(req_src_ch0), .req_src_ch1(req_src_ch1), .req_src_ch2(req_src_ch2),
      .req_old_ch0(req_old_ch0), .req_old_ch1(req_old_ch1), .req_old_ch2(req_old_ch2),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_ch0(rsp_out_ch0), .rsp_out_ch1(rsp_out_ch1), .rsp_out_ch2(rsp_out_ch2)
   );

   gamma_pixel_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_src_ch0(req_src_ch0), .req_src_ch1(req_src_ch1), .req_src_ch2(req_src_ch2),
      .req_old_ch0(req_old_ch0), .req_old_ch1(req_old_ch1), .req_old_ch2(req_old_ch2),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_ch0(rsp_out_ch0), .rsp_out_ch1(rsp_out_ch1), .rsp_out_ch2(rsp_out_ch2),
      .fail_count(fail_count), .pixels_pending(pixels_pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random at the configured rate.
   always @(posedge clock) begin
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // A channel value that favors the ends of the range.
   function automatic logic [CH_W-1:0] pick_channel();
      logic [CH_W-1:0] ends [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
      if ($urandom_range(99) < 20) return ends[$urandom_range(3)];
      return CH_W'($urandom_range(255));
   endfunction

   // Write one configuration register at the next edge.
   task automatic write_reg(input logic [1:0] idx, input logic [GAMMA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Offer one pixel and hold it until the transfer happens.
   task automatic send_pixel(input logic [CH_W-1:0] s0, input logic [CH_W-1:0] s1,
                             input logic [CH_W-1:0] s2, input logic [CH_W-1:0] o0,
                             input logic [CH_W-1:0] o1, input logic [CH_W-1:0] o2);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_src_ch0 <= s0;
      req_src_ch1 <= s1;
      req_src_ch2 <= s2;
      req_old_ch0 <= o0;
      req_old_ch1 <= o1;
      req_old_ch2 <= o2;
      do begin
         @(negedge clock);
      end while (req_stall);
      @(posedge clock);
   endtask

   // Stop offering, then wait until every predicted pixel has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_GAMMA;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_src_ch0 = '0;
      req_src_ch1 = '0;
      req_src_ch2 = '0;
      req_old_ch0 = '0;
      req_old_ch1 = '0;
      req_old_ch2 = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      quiet_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels at reset settings: extremes and mixed bits.
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd254);
      send_pixel(8'hAA, 8'h55, 8'h80, 8'h55, 8'hAA, 8'h7F);
      drain();

      // Directed pixels with darkening gamma (clamp to black) and brightening (clamp to white).
      write_reg(CSR_GAMMA, 16'd2048);
      write_reg(CSR_PREV_GAMMA, 16'd4096);
      send_pixel(8'd128, 8'd200, 8'd0, 8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd1, 8'd64, 8'd10, 8'd0, 8'd255);
      drain();
      write_reg(CSR_GAMMA, 16'd8192);
      write_reg(CSR_PREV_GAMMA, 16'd4096);
      send_pixel(8'd128, 8'd1, 8'd0, 8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd200, 8'd64, 8'd0, 8'd0, 8'd255);
      drain();
      write_reg(CSR_DEPTH, 16'd0);
      send_pixel(8'd12, 8'd255, 8'd0, 8'd77, 8'd0, 8'd255);
      drain();

      // Random phases over the gamma settings, idling changing by thirds.
      for (int s = 0; s < NUM_SETS; s++) begin
         if (s < 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 72;
         end else if (s < 6) begin
            send_idle_pct = 72;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_reg(CSR_GAMMA, set_gamma[s]);
         write_reg(CSR_PREV_GAMMA, set_prev[s]);
         write_reg(CSR_DEPTH, 16'(set_depth[s]));
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            send_pixel(pick_channel(), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel(), pick_channel());
         end
         drain();
      end

      if (fail_count == 0 && pixels_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
src/gcr_pkg.sv
src/gcr_lane.sv
src/gcr_merge.sv
src/gamma_correct_rgb_pixel_top.sv
sim/gamma_pixel_checker.sv
sim/testbench.sv
